// ===== src/lrbc_pkg.sv =====
// lrbc_pkg: shared types, codes and constants of the link retry backoff controller
// no dependencies; used by lrbc_ctrl, lrbc_dp, the top level and the testbench

package lrbc_pkg;

  // table size
  localparam int unsigned MAX_ENTRIES_DEF = 8;

  // register reset values
  localparam logic [15:0] RST_CONNECT_TIMEOUT = 16'd15000;
  localparam logic [15:0] RST_INITIAL_BACKOFF = 16'd1000;
  localparam logic [15:0] RST_MAX_BACKOFF     = 16'd60000;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_NETWORK_COUNT   = 3'd0,
    CFG_PRIORITY_WORD   = 3'd1,
    CFG_CONNECT_TIMEOUT = 3'd2,
    CFG_INITIAL_BACKOFF = 3'd3,
    CFG_MAX_BACKOFF     = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OP_START = 1'b0,
    OP_CHECK = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    LS_DISCONNECTED = 2'd0,
    LS_CONNECTING   = 2'd1,
    LS_CONNECTED    = 2'd2,
    LS_FAILED       = 2'd3
  } link_state_e;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_SORT = 2'd1,
    SEQ_EXEC = 2'd2
  } seq_state_e;

  // controller to datapath
  typedef struct packed {
    logic latch;      // capture the accepted beat
    logic sort_step;  // place one entry into the order table
    logic exec;       // update link state and load the result register
  } lrbc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_sort; // incoming beat is a start with at least one entry
    logic sort_last;  // current sort step places the last entry
    logic out_free;   // result register can take a new result
  } lrbc_sts_t;

  // 8-bit priority of an entry; entries past the eighth have priority zero
  function automatic logic [7:0] prio_of(logic [63:0] word, logic [3:0] entry);
    logic [7:0] p;
    p = 8'd0;
    if (!entry[3]) begin
      p = word[{entry[2:0], 3'b000} +: 8];
    end
    return p;
  endfunction

endpackage

// ===== src/lrbc_if.sv =====
// lrbc_if: valid/ready channel interfaces for input and result beats
// no dependencies

interface lrbc_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] now_ms;
  logic        link_up;

  modport source (output valid, output opcode, output now_ms, output link_up, input ready);
  modport sink (input valid, input opcode, input now_ms, input link_up, output ready);
endinterface

interface lrbc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] link_state;
  logic       connect_req;
  logic [2:0] connect_entry;
  logic       disconnect_req;

  modport source (output valid, output link_state, output connect_req,
                  output connect_entry, output disconnect_req, input ready);
  modport sink (input valid, input link_state, input connect_req,
                input connect_entry, input disconnect_req, output ready);
endinterface

// ===== src/lrbc_ctrl.sv =====
// lrbc_ctrl: sequencing state machine (accept, sort walk, execute)
// depends on lrbc_pkg

module lrbc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lrbc_pkg::lrbc_sts_t   sts_i,
  output lrbc_pkg::lrbc_cmd_t   cmd_o
);

  lrbc_pkg::seq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrbc_pkg::SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == lrbc_pkg::SEQ_IDLE);
    unique case (state_q)
      lrbc_pkg::SEQ_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = sts_i.start_sort ? lrbc_pkg::SEQ_SORT : lrbc_pkg::SEQ_EXEC;
        end
      end
      lrbc_pkg::SEQ_SORT: begin
        cmd_o.sort_step = 1'b1;
        if (sts_i.sort_last) begin
          state_d = lrbc_pkg::SEQ_EXEC;
        end
      end
      lrbc_pkg::SEQ_EXEC: begin
        // hold while the previous result is still waiting
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = lrbc_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_d = lrbc_pkg::SEQ_IDLE;
      end
    endcase
  end

endmodule

// ===== src/lrbc_dp.sv =====
// lrbc_dp: configuration registers, order table, rank sorter, link state and result register
// depends on lrbc_pkg

module lrbc_dp #(
  parameter int unsigned MAX_ENTRIES = lrbc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i,
  input  logic                opcode_i,
  input  logic [31:0]         now_ms_i,
  input  logic                link_up_i,
  input  logic                out_ready_i,
  input  lrbc_pkg::lrbc_cmd_t cmd_i,
  output lrbc_pkg::lrbc_sts_t sts_o,
  output logic                out_valid_o,
  output logic [1:0]          link_state_o,
  output logic                connect_req_o,
  output logic [2:0]          connect_entry_o,
  output logic                disconnect_req_o
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  // configuration
  logic [3:0]  net_count_q;
  logic [63:0] prio_word_q;
  logic [15:0] timeout_q;
  logic [15:0] init_boff_q;
  logic [15:0] max_boff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      net_count_q <= 4'd0;
      prio_word_q <= 64'd0;
      timeout_q   <= lrbc_pkg::RST_CONNECT_TIMEOUT;
      init_boff_q <= lrbc_pkg::RST_INITIAL_BACKOFF;
      max_boff_q  <= lrbc_pkg::RST_MAX_BACKOFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lrbc_pkg::CFG_NETWORK_COUNT:   net_count_q <= cfg_data_i[3:0];
        lrbc_pkg::CFG_PRIORITY_WORD:   prio_word_q <= cfg_data_i;
        lrbc_pkg::CFG_CONNECT_TIMEOUT: timeout_q   <= cfg_data_i[15:0];
        lrbc_pkg::CFG_INITIAL_BACKOFF: init_boff_q <= cfg_data_i[15:0];
        lrbc_pkg::CFG_MAX_BACKOFF:     max_boff_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // live entry count, clamped to the table size
  logic [CNT_W-1:0] n_live;
  assign n_live = ({1'b0, net_count_q} > 5'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                          : CNT_W'(net_count_q);

  // captured beat
  logic        op_q;
  logic [31:0] now_q;
  logic        up_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= opcode_i;
      now_q <= now_ms_i;
      up_q  <= link_up_i;
    end
  end

  // sort walk: rank of entry sort_q among live entries, ties by index
  logic [IDX_W-1:0] sort_q;
  logic [CNT_W-1:0] rank;
  logic [7:0]       prio_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_q <= '0;
    end else if (cmd_i.latch) begin
      sort_q <= '0;
    end else if (cmd_i.sort_step) begin
      sort_q <= sort_q + IDX_W'(1);
    end
  end

  assign prio_cur = lrbc_pkg::prio_of(prio_word_q, 4'(sort_q));

  always_comb begin
    rank = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if ((CNT_W'(k) < n_live) &&
          ((lrbc_pkg::prio_of(prio_word_q, 4'(k)) < prio_cur) ||
           ((lrbc_pkg::prio_of(prio_word_q, 4'(k)) == prio_cur) && (IDX_W'(k) < sort_q)))) begin
        rank = rank + CNT_W'(1);
      end
    end
  end

  logic [IDX_W-1:0] order_q [MAX_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sort_step) begin
      order_q[rank[IDX_W-1:0]] <= sort_q;
    end
  end

  // link state
  lrbc_pkg::link_state_e lst_q, lst_d;
  logic [IDX_W-1:0]      try_q, try_d;
  logic [31:0]           last_q, last_d;
  logic [15:0]           boff_q, boff_d;
  logic [31:0]           elapsed;
  logic [CNT_W-1:0]      try_inc;
  logic [16:0]           boff_dbl;
  logic [IDX_W-1:0]      rd_addr;
  logic                  req, disc;
  logic [2:0]            entry;

  assign elapsed  = now_q - last_q;
  assign try_inc  = CNT_W'(try_q) + CNT_W'(1);
  assign boff_dbl = {boff_q, 1'b0};

  always_comb begin
    lst_d   = lst_q;
    try_d   = try_q;
    last_d  = last_q;
    boff_d  = boff_q;
    req     = 1'b0;
    disc    = 1'b0;
    rd_addr = try_q;
    if (op_q == lrbc_pkg::OP_START) begin
      try_d   = '0;
      rd_addr = '0;
      boff_d  = init_boff_q;
      if (n_live != '0) begin
        req = 1'b1;
      end else begin
        lst_d = lrbc_pkg::LS_FAILED;
      end
    end else begin
      unique case (lst_q)
        lrbc_pkg::LS_CONNECTED: begin
          if (!up_q) begin
            lst_d  = lrbc_pkg::LS_DISCONNECTED;
            try_d  = '0;
            boff_d = init_boff_q;
          end
        end
        lrbc_pkg::LS_CONNECTING: begin
          if (up_q) begin
            lst_d  = lrbc_pkg::LS_CONNECTED;
            boff_d = init_boff_q;
          end else if (elapsed > {16'd0, timeout_q}) begin
            disc = 1'b1;
            if (try_inc >= n_live) begin
              try_d  = '0;
              lst_d  = lrbc_pkg::LS_DISCONNECTED;
              last_d = now_q;
            end else begin
              try_d   = IDX_W'(try_inc);
              rd_addr = IDX_W'(try_inc);
              req     = 1'b1;
            end
          end
        end
        lrbc_pkg::LS_DISCONNECTED, lrbc_pkg::LS_FAILED: begin
          if ((n_live != '0) && (elapsed > {16'd0, boff_q})) begin
            boff_d = (boff_dbl > {1'b0, max_boff_q}) ? max_boff_q : boff_dbl[15:0];
            req    = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (req) begin
      lst_d  = lrbc_pkg::LS_CONNECTING;
      last_d = now_q;
    end
  end

  assign entry = req ? 3'(order_q[rd_addr]) : 3'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lst_q  <= lrbc_pkg::LS_DISCONNECTED;
      try_q  <= '0;
      last_q <= 32'd0;
      boff_q <= lrbc_pkg::RST_INITIAL_BACKOFF;
    end else if (cmd_i.exec) begin
      lst_q  <= lst_d;
      try_q  <= try_d;
      last_q <= last_d;
      boff_q <= boff_d;
    end
  end

  // result register
  logic       out_valid_q;
  logic [1:0] res_state_q;
  logic       res_req_q;
  logic [2:0] res_entry_q;
  logic       res_disc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.exec | (out_valid_q & ~out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_state_q <= lst_d;
      res_req_q   <= req;
      res_entry_q <= entry;
      res_disc_q  <= disc;
    end
  end

  assign sts_o.start_sort = (opcode_i == lrbc_pkg::OP_START) && (n_live != '0);
  assign sts_o.sort_last  = ((CNT_W'(sort_q) + CNT_W'(1)) == n_live);
  assign sts_o.out_free   = ~out_valid_q | out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign link_state_o     = res_state_q;
  assign connect_req_o    = res_req_q;
  assign connect_entry_o  = res_entry_q;
  assign disconnect_req_o = res_disc_q;

endmodule

// ===== src/link_retry_backoff_controller_unit.sv =====
// a check beat goes from idle to execute, which loads the result register once it is
//   free; a start beat with n live entries first passes the sort walk, the rank sorter
//   placing one entry per cycle; a new beat is taken only when idle again
// a new beat is taken while the previous result still waits in the result register
// reset: asynchronous, active low; registers to their defaults, link disconnected,
//   order table contents undefined until a start beat has sorted it
// top level of the link retry backoff controller; depends on lrbc_pkg, lrbc_if,
// lrbc_ctrl and lrbc_dp

module link_retry_backoff_controller_unit #(
  parameter int unsigned MAX_ENTRIES = lrbc_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  lrbc_in_if.sink     in_i,
  lrbc_out_if.source  out_o
);

  // command and status between the sequencer and the datapath
  lrbc_pkg::lrbc_cmd_t cmd;
  lrbc_pkg::lrbc_sts_t sts;

  // sequencer: idle -> (sort walk) -> execute, ready only when idle
  lrbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: config, order table, link state and the result register
  lrbc_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (in_i.opcode),
    .now_ms_i         (in_i.now_ms),
    .link_up_i        (in_i.link_up),
    .out_ready_i      (out_o.ready),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_o.valid),
    .link_state_o     (out_o.link_state),
    .connect_req_o    (out_o.connect_req),
    .connect_entry_o  (out_o.connect_entry),
    .disconnect_req_o (out_o.disconnect_req)
  );

  // a connect request always leaves the link in the connecting state
  a_req_connecting : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.connect_req |-> out_o.link_state == lrbc_pkg::LS_CONNECTING)
    else $error("connect request without connecting state");

  // an abort that issues no new attempt ends disconnected
  a_abort_disc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.disconnect_req && !out_o.connect_req
      |-> out_o.link_state == lrbc_pkg::LS_DISCONNECTED)
    else $error("abort without retry not disconnected");

  // in the cycle after a beat is taken the sequencer is busy
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("beat accepted on consecutive cycles");

  // a result is only loaded when the result register is free
  a_exec_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> sts.out_free)
    else $error("result register overwritten");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking testbench of the link retry backoff controller
// depends on lrbc_pkg, lrbc_if and link_retry_backoff_controller_unit

module tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_BEATS  = 125;
  localparam int unsigned PHASE_COUNT  = 6;
  localparam int unsigned REPORT_LIMIT = 10;

  // one result beat as the sequencer should produce it
  typedef struct packed {
    lrbc_pkg::link_state_e link_state;
    logic                  connect_req;
    logic [2:0]            connect_entry;
    logic                  disconnect_req;
  } link_out_t;

  // one row of the directed part: a register write or an input beat
  typedef struct {
    bit                 is_cfg;
    lrbc_pkg::cfg_reg_e reg_idx;
    logic [63:0]        data;
    lrbc_pkg::opcode_e  op;
    logic [31:0]        now;
    logic               up;
    bit                 has_exp;
    link_out_t          exp;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;

  lrbc_in_if  in_if ();
  lrbc_out_if out_if ();

  link_retry_backoff_controller_unit DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the registers
  logic [3:0]  net_count;
  logic [63:0] prio_word;
  logic [15:0] timeout_ms;
  logic [15:0] init_backoff_ms;
  logic [15:0] boff_limit_ms;

  // shadow copy of the sequencer state
  lrbc_pkg::link_state_e seq_state;
  logic [2:0]            order_tbl [lrbc_pkg::MAX_ENTRIES_DEF];
  int unsigned           try_pos;
  logic [31:0]           last_try_ms;
  logic [31:0]           backoff_now;

  // results still owed by the block, oldest first
  link_out_t   awaited_outputs [$];

  int unsigned failures    = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold     = 0;    // long receiver hold-off, counted down by the receiver
  bit          tx_idle_on  = 1'b1;
  bit          rx_idle_on  = 1'b1;
  logic [31:0] clock_ms    = '0;   // running uptime fed to the random beats

  // stable insertion sort of the live entries by ascending priority
  function automatic void sort_entries_by_prio(int unsigned n);
    int unsigned i;
    int unsigned j;
    logic [2:0]  e;
    for (i = 0; i < n; i++) order_tbl[i] = 3'(i);
    for (i = 1; i < n; i++) begin
      e = order_tbl[i];
      j = i;
      while (j > 0 && prio_word[8 * order_tbl[j - 1] +: 8] > prio_word[8 * e +: 8]) begin
        order_tbl[j] = order_tbl[j - 1];
        j--;
      end
      order_tbl[j] = e;
    end
  endfunction

  // new connect attempt at the current try position
  function automatic logic [2:0] launch_attempt(logic [31:0] now);
    seq_state   = lrbc_pkg::LS_CONNECTING;
    last_try_ms = now;
    return order_tbl[try_pos];
  endfunction

  // steps the shadow sequencer by one accepted beat and returns its result
  function automatic link_out_t advance_sequencer(lrbc_pkg::opcode_e op, logic [31:0] now,
                                                  logic up);
    link_out_t   r;
    int unsigned n;
    logic [31:0] elapsed;
    logic [31:0] doubled;
    n       = (net_count > 4'd8) ? 8 : int'(net_count);
    elapsed = now - last_try_ms;   // wraps modulo 2^32
    r       = '0;
    if (op == lrbc_pkg::OP_START) begin
      sort_entries_by_prio(n);
      try_pos     = 0;
      backoff_now = 32'(init_backoff_ms);
      if (n > 0) begin
        r.connect_entry = launch_attempt(now);
        r.connect_req   = 1'b1;
      end else begin
        seq_state = lrbc_pkg::LS_FAILED;
      end
    end else if (seq_state == lrbc_pkg::LS_CONNECTED) begin
      // link lost: back to the head of the order, no retry on this beat
      if (!up) begin
        seq_state   = lrbc_pkg::LS_DISCONNECTED;
        try_pos     = 0;
        backoff_now = 32'(init_backoff_ms);
      end
    end else if (seq_state == lrbc_pkg::LS_CONNECTING) begin
      if (up) begin
        seq_state   = lrbc_pkg::LS_CONNECTED;
        backoff_now = 32'(init_backoff_ms);
      end else if (elapsed > 32'(timeout_ms)) begin
        r.disconnect_req = 1'b1;
        try_pos++;
        if (try_pos >= n) begin
          // every entry tried: wait out the backoff from here
          try_pos     = 0;
          seq_state   = lrbc_pkg::LS_DISCONNECTED;
          last_try_ms = now;
        end else begin
          r.connect_entry = launch_attempt(now);
          r.connect_req   = 1'b1;
        end
      end
    end else if (n > 0 && elapsed > backoff_now) begin
      // retry from disconnected or failed, backoff doubles and saturates
      doubled         = backoff_now << 1;
      backoff_now     = (doubled > 32'(boff_limit_ms)) ? 32'(boff_limit_ms) : doubled;
      r.connect_entry = launch_attempt(now);
      r.connect_req   = 1'b1;
    end
    r.link_state = seq_state;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(lrbc_pkg::cfg_reg_e idx, logic [63:0] data);
    stim_row_t r;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.data    = data;
    r.op      = lrbc_pkg::OP_CHECK;
    r.now     = '0;
    r.up      = 1'b0;
    r.has_exp = 1'b0;
    r.exp     = '0;
    return r;
  endfunction

  function automatic stim_row_t beat_row(lrbc_pkg::opcode_e op, logic [31:0] now, logic up);
    stim_row_t r;
    r         = cfg_row(lrbc_pkg::CFG_NETWORK_COUNT, '0);
    r.is_cfg  = 1'b0;
    r.op      = op;
    r.now     = now;
    r.up      = up;
    return r;
  endfunction

  // beat whose result is plain: no request of either kind, only the state
  function automatic stim_row_t settled_row(lrbc_pkg::opcode_e op, logic [31:0] now, logic up,
                                            lrbc_pkg::link_state_e st);
    stim_row_t r;
    r                  = beat_row(op, now, up);
    r.has_exp          = 1'b1;
    r.exp.link_state   = st;
    return r;
  endfunction

  // register write, taken at the next rising edge; caller lowers the enable afterwards
  task automatic write_reg(lrbc_pkg::cfg_reg_e idx, logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      lrbc_pkg::CFG_NETWORK_COUNT:   net_count       = data[3:0];
      lrbc_pkg::CFG_PRIORITY_WORD:   prio_word       = data;
      lrbc_pkg::CFG_CONNECT_TIMEOUT: timeout_ms      = data[15:0];
      lrbc_pkg::CFG_INITIAL_BACKOFF: init_backoff_ms = data[15:0];
      lrbc_pkg::CFG_MAX_BACKOFF:     boff_limit_ms   = data[15:0];
      default: ;
    endcase
  endtask

  // sender goes quiet until every owed result has come back
  task automatic settle();
    in_if.valid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // offers one beat, waits for the handshake, then books its result
  task automatic send_beat(lrbc_pkg::opcode_e op, logic [31:0] now, logic up, bit has_exp,
                           link_out_t known);
    link_out_t predicted;
    in_if.valid   <= 1'b1;
    in_if.opcode  <= op;
    in_if.now_ms  <= now;
    in_if.link_up <= up;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    predicted = advance_sequencer(op, now, up);
    awaited_outputs.push_back(has_exp ? known : predicted);
    if (tx_idle_on && $urandom_range(0, 99) < 15) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // random beat shaped by the shadow state, so that timeouts, retries and
  // link changes keep happening; some beats land right on the expiry edge
  task automatic random_beat();
    logic [31:0]       limit;
    logic [31:0]       now;
    lrbc_pkg::opcode_e op;
    logic              up;
    int unsigned       k;
    limit = (seq_state == lrbc_pkg::LS_CONNECTING) ? 32'(timeout_ms) : backoff_now;
    k     = $urandom_range(0, 99);
    if (k < 12) now = last_try_ms + limit + $urandom_range(0, 1);
    else if (k < 16) now = $urandom;
    else now = clock_ms + $urandom_range(0, limit / 3 + 1);
    clock_ms = now;
    op = ($urandom_range(0, 99) < 6) ? lrbc_pkg::OP_START : lrbc_pkg::OP_CHECK;
    case (seq_state)
      lrbc_pkg::LS_CONNECTING: up = ($urandom_range(0, 99) < 20);
      lrbc_pkg::LS_CONNECTED:  up = ($urandom_range(0, 99) < 90);
      default:                 up = 1'($urandom_range(0, 1));
    endcase
    send_beat(op, now, up, 1'b0, '0);
  endtask

  // register setting of one random phase; the upper data bits carry noise
  task automatic configure_phase(int unsigned phase);
    logic [3:0]  cnt;
    logic [63:0] prio;
    logic [15:0] tmo;
    logic [15:0] ib;
    logic [15:0] mb;
    int unsigned b;
    prio = {$urandom, $urandom};
    case (phase)
      0: begin
        cnt = 4'($urandom_range(1, 8));
        tmo = 16'($urandom_range(1, 200));
        ib  = 16'($urandom_range(1, 100));
        mb  = 16'($urandom_range(1, 2000));
      end
      1: begin
        // top extremes everywhere
        cnt  = 4'd8;
        prio = '1;
        tmo  = '1;
        ib   = '1;
        mb   = '1;
      end
      2: begin
        // bottom extremes, backoff pinned at one
        cnt  = 4'd1;
        prio = '0;
        tmo  = 16'd1;
        ib   = 16'd1;
        mb   = 16'd1;
      end
      3: begin
        // no entries: starts fail and retries never fire
        cnt = 4'd0;
        tmo = 16'($urandom_range(1, 500));
        ib  = 16'($urandom_range(1, 500));
        mb  = 16'($urandom_range(1, 500));
      end
      4: begin
        // count above the table size, priorities with many ties
        cnt = 4'($urandom_range(9, 15));
        for (b = 0; b < 8; b++) prio[8 * b +: 8] = 8'($urandom_range(0, 3));
        tmo = 16'($urandom_range(1, 1000));
        ib  = 16'($urandom_range(1, 500));
        mb  = 16'($urandom_range(1, 65535));
      end
      default: begin
        cnt = 4'($urandom_range(0, 15));
        tmo = 16'($urandom_range(1, 65535));
        ib  = 16'($urandom_range(1, 65535));
        mb  = 16'($urandom_range(1, 65535));
      end
    endcase
    write_reg(lrbc_pkg::CFG_NETWORK_COUNT,   {$urandom, 28'($urandom), cnt});
    write_reg(lrbc_pkg::CFG_PRIORITY_WORD,   prio);
    write_reg(lrbc_pkg::CFG_CONNECT_TIMEOUT, {$urandom, 16'($urandom), tmo});
    write_reg(lrbc_pkg::CFG_INITIAL_BACKOFF, {$urandom, 16'($urandom), ib});
    write_reg(lrbc_pkg::CFG_MAX_BACKOFF,     {$urandom, 16'($urandom), mb});
    cfg_we_i <= 1'b0;
  endtask

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: checks every result beat against the oldest owed one and
  // stalls in random bursts, or for a long stretch when asked
  initial begin
    int unsigned stall;
    link_out_t   want;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (awaited_outputs.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("%0t: result beat with nothing owed, state %0d req %0b entry %0d disc %0b",
                     $time, out_if.link_state, out_if.connect_req, out_if.connect_entry,
                     out_if.disconnect_req);
        end else begin
          want = awaited_outputs.pop_front();
          if (out_if.link_state !== want.link_state ||
              out_if.connect_req !== want.connect_req ||
              out_if.connect_entry !== want.connect_entry ||
              out_if.disconnect_req !== want.disconnect_req) begin
            failures++;
            if (failures <= REPORT_LIMIT)
              $display("%0t: mismatch, expected state %0d req %0b entry %0d disc %0b, %s",
                       $time, want.link_state, want.connect_req, want.connect_entry,
                       want.disconnect_req,
                       $sformatf("got state %0d req %0b entry %0d disc %0b",
                                 out_if.link_state, out_if.connect_req,
                                 out_if.connect_entry, out_if.disconnect_req));
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 99) < 12) begin
        stall = $urandom_range(0, 7);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // stimulus: directed rows first, then random phases under several settings
  initial begin
    stim_row_t   rows [$];
    stim_row_t   row;
    bit          cfg_open;
    int unsigned phase;
    int unsigned i;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= lrbc_pkg::CFG_NETWORK_COUNT;
    cfg_data_i    <= '0;
    in_if.valid   <= 1'b0;
    in_if.opcode  <= lrbc_pkg::OP_CHECK;
    in_if.now_ms  <= '0;
    in_if.link_up <= 1'b0;

    // shadow state after reset
    net_count       = '0;
    prio_word       = '0;
    timeout_ms      = lrbc_pkg::RST_CONNECT_TIMEOUT;
    init_backoff_ms = lrbc_pkg::RST_INITIAL_BACKOFF;
    boff_limit_ms   = lrbc_pkg::RST_MAX_BACKOFF;
    seq_state       = lrbc_pkg::LS_DISCONNECTED;
    try_pos         = 0;
    last_try_ms     = '0;
    backoff_now     = 32'(lrbc_pkg::RST_INITIAL_BACKOFF);
    foreach (order_tbl[k]) order_tbl[k] = '0;

    // out of reset with no entries: nothing to try, a start fails
    rows.push_back(settled_row(lrbc_pkg::OP_CHECK, 32'd0, 1'b0, lrbc_pkg::LS_DISCONNECTED));
    rows.push_back(settled_row(lrbc_pkg::OP_START, 32'hFFFF_FFFF, 1'b1, lrbc_pkg::LS_FAILED));
    rows.push_back(settled_row(lrbc_pkg::OP_CHECK, 32'd5, 1'b0, lrbc_pkg::LS_FAILED));
    // count written as 15 clamps to the full table; priorities 00 and ff with ties
    rows.push_back(cfg_row(lrbc_pkg::CFG_NETWORK_COUNT, 64'hA5A5_A5A5_A5A5_A5AF));
    rows.push_back(cfg_row(lrbc_pkg::CFG_PRIORITY_WORD, 64'h0301_03FF_0001_FF00));
    rows.push_back(cfg_row(lrbc_pkg::CFG_CONNECT_TIMEOUT, 64'd1));
    // sorted start, elapsed equal to the timeout, timeout to the next entry,
    // success, then the link lost
    rows.push_back(beat_row(lrbc_pkg::OP_START, 32'd100, 1'b0));
    rows.push_back(beat_row(lrbc_pkg::OP_CHECK, 32'd101, 1'b0));
    rows.push_back(beat_row(lrbc_pkg::OP_CHECK, 32'd102, 1'b0));
    rows.push_back(beat_row(lrbc_pkg::OP_CHECK, 32'd104, 1'b1));
    rows.push_back(beat_row(lrbc_pkg::OP_CHECK, 32'd5000, 1'b0));
    // count lowered after the sort keeps the older order; backoff saturates at three
    rows.push_back(cfg_row(lrbc_pkg::CFG_NETWORK_COUNT, 64'h5A5A_0000_0000_0002));
    rows.push_back(cfg_row(lrbc_pkg::CFG_INITIAL_BACKOFF, 64'h0000_FFFF_0000_0001));
    rows.push_back(cfg_row(lrbc_pkg::CFG_MAX_BACKOFF, 64'h8000_0000_0000_0003));
    rows.push_back(beat_row(lrbc_pkg::OP_CHECK, 32'd5001, 1'b0));
    rows.push_back(beat_row(lrbc_pkg::OP_CHECK, 32'd5003, 1'b0));
    rows.push_back(beat_row(lrbc_pkg::OP_CHECK, 32'd5005, 1'b0));
    rows.push_back(beat_row(lrbc_pkg::OP_CHECK, 32'd5008, 1'b0));
    rows.push_back(beat_row(lrbc_pkg::OP_CHECK, 32'd5009, 1'b0));
    // timeout measured across the wrap of the uptime
    rows.push_back(beat_row(lrbc_pkg::OP_START, 32'hFFFF_FFFE, 1'b0));
    rows.push_back(beat_row(lrbc_pkg::OP_CHECK, 32'd0, 1'b0));
    // every timing register at its maximum
    rows.push_back(cfg_row(lrbc_pkg::CFG_CONNECT_TIMEOUT, 64'hFFFF_FFFF_FFFF_FFFF));
    rows.push_back(cfg_row(lrbc_pkg::CFG_INITIAL_BACKOFF, 64'hFFFF_FFFF_FFFF_FFFF));
    rows.push_back(cfg_row(lrbc_pkg::CFG_MAX_BACKOFF, 64'hFFFF_FFFF_FFFF_FFFF));
    rows.push_back(beat_row(lrbc_pkg::OP_CHECK, 32'd65535, 1'b0));
    rows.push_back(beat_row(lrbc_pkg::OP_CHECK, 32'd65536, 1'b0));
    rows.push_back(beat_row(lrbc_pkg::OP_CHECK, 32'd131071, 1'b0));
    rows.push_back(beat_row(lrbc_pkg::OP_START, 32'd0, 1'b1));
    rows.push_back(beat_row(lrbc_pkg::OP_CHECK, 32'd0, 1'b1));
    rows.push_back(beat_row(lrbc_pkg::OP_CHECK, 32'd1, 1'b0));
    rows.push_back(beat_row(lrbc_pkg::OP_CHECK, 32'd65537, 1'b0));
    // count dropped to zero while connecting: the timeout ends the round
    rows.push_back(cfg_row(lrbc_pkg::CFG_NETWORK_COUNT, 64'd0));
    rows.push_back(beat_row(lrbc_pkg::OP_CHECK, 32'd200000, 1'b0));
    rows.push_back(settled_row(lrbc_pkg::OP_START, 32'd7, 1'b0, lrbc_pkg::LS_FAILED));
    rows.push_back(settled_row(lrbc_pkg::OP_CHECK, 32'h8000_0000, 1'b1, lrbc_pkg::LS_FAILED));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register writes only go in once the block has returned every result
    cfg_open = 1'b0;
    foreach (rows[k]) begin
      row = rows[k];
      if (row.is_cfg) begin
        if (!cfg_open) settle();
        write_reg(row.reg_idx, row.data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_we_i <= 1'b0;
        cfg_open = 1'b0;
        send_beat(row.op, row.now, row.up, row.has_exp, row.exp);
      end
    end
    clock_ms = 32'd200000;

    // the directed start with the full table has filled every order entry,
    // so a count raised later never reaches an unsorted slot
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      settle();
      configure_phase(phase);
      // receiver holds off while the sender keeps offering: the block backs up
      if (phase == 1) rx_hold = 150;
      for (i = 0; i < PHASE_BEATS; i++) begin
        tx_idle_on = !(phase == 1 && i < 40) && !(phase == PHASE_COUNT - 1 &&
                                                   i >= PHASE_BEATS / 2);
        rx_idle_on = !(phase == PHASE_COUNT - 1 && i >= PHASE_BEATS / 2);
        // sender pause until the block has drained
        if (phase == 0 && i == PHASE_BEATS / 2) settle();
        random_beat();
      end
    end

    settle();
    repeat (16) @(posedge clk_i);
    if (failures == 0 && awaited_outputs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
